FILE: hdl/stoq_pkg.sv
package stoq_pkg;

	localparam int OP_W     = 2;
	localparam int ID_W     = 16;
	localparam int TICK_W   = 16;
	localparam int ACTIVE_W = 7;

	typedef enum logic [OP_W-1:0] {
		OP_ADD   = 2'd0,
		OP_TICK  = 2'd1,
		OP_CHECK = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	// per-cycle command broadcast to every cell of the chain
	typedef enum logic [1:0] {
		CMD_HOLD,
		CMD_INSERT,
		CMD_TICK,
		CMD_SHIFT
	} cell_cmd_t;

	typedef struct packed {
		logic [TICK_W-1:0] cnt;
		logic [ID_W-1:0]   id;
	} entry_t;

endpackage

FILE: hdl/stoq_in_if.sv
interface stoq_in_if;
	logic                        valid;
	logic                        ready;
	logic [stoq_pkg::OP_W-1:0]   operation;
	logic [stoq_pkg::ID_W-1:0]   event_id;
	logic [stoq_pkg::TICK_W-1:0] tick_count;

	modport source (output valid, output operation, output event_id, output tick_count,
		input ready);
	modport sink (input valid, input operation, input event_id, input tick_count,
		output ready);
endinterface

FILE: hdl/stoq_out_if.sv
interface stoq_out_if;
	logic                          valid;
	logic                          ready;
	logic                          fired;
	logic [stoq_pkg::ID_W-1:0]     fired_id;
	logic                          add_accepted;
	logic [stoq_pkg::ACTIVE_W-1:0] active_count;

	modport source (output valid, output fired, output fired_id, output add_accepted,
		output active_count, input ready);
	modport sink (input valid, input fired, input fired_id, input add_accepted,
		input active_count, output ready);
endinterface

FILE: hdl/stoq_cell.sv
module stoq_cell (
	input  logic                clk,
	input  stoq_pkg::cell_cmd_t cmd,
	input  logic                occ,
	input  stoq_pkg::entry_t    new_ent,
	input  stoq_pkg::entry_t    left_ent,
	input  logic                left_le,
	input  stoq_pkg::entry_t    right_ent,
	output stoq_pkg::entry_t    ent,
	output logic                le
);
	import stoq_pkg::*;

	entry_t ent_q;

	// occupied and not later than the new event: stays put on insert
	assign le  = occ && (ent_q.cnt <= new_ent.cnt);
	assign ent = ent_q;

	always_ff @(posedge clk) begin
		case (cmd)
			CMD_INSERT: begin
				if (!le) begin
					ent_q <= left_le ? new_ent : left_ent;
				end
			end
			CMD_TICK: begin
				if (ent_q.cnt != '0) begin
					ent_q.cnt <= ent_q.cnt - TICK_W'(1);
				end
			end
			CMD_SHIFT: ent_q <= right_ent;
			default: ent_q <= ent_q;
		endcase
	end
endmodule

FILE: hdl/sorted_timeout_event_queue_unit.sv
// Sorted timeout event queue: a chain of DEPTH cells holds pending events, each a
// remaining tick count and an event id, sorted ascending by count with ties kept in
// arrival order. Every transaction on req is one operation (add, tick, check, clear)
// and produces exactly one transaction on rsp. All cells act in parallel on a
// broadcast command (insert shifts the tail right, a check that pops the head
// shifts left, tick decrements every nonzero count). The result sits in an output
// register, and req is ready whenever that register is empty or being taken, so one
// transaction per clock is sustained while rsp is ready. Unoccupied cells are
// tracked only by the pending count; there is no clearing pass after reset.
module sorted_timeout_event_queue_unit #(
	parameter int DEPTH = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	stoq_in_if.sink        req,
	stoq_out_if.source     rsp
);
	import stoq_pkg::*;

	localparam int COUNT_W = $clog2(DEPTH + 1);

	// pending event count, the only control state of the chain
	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] count_d;

	// result register
	logic                out_valid_q;
	logic                fired_q;
	logic [ID_W-1:0]     fired_id_q;
	logic                add_ok_q;
	logic [ACTIVE_W-1:0] active_q;

	// chain wiring
	entry_t     cell_ent [DEPTH];
	logic       cell_le  [DEPTH];
	logic       cell_occ [DEPTH];
	entry_t     new_ent;
	cell_cmd_t  cmd;

	logic acc;
	logic full;
	logic add_ok;
	logic pop_ok;
	op_t  op;

	assign op      = op_t'(req.operation);
	assign acc     = req.valid && req.ready;
	assign req.ready = !out_valid_q || rsp.ready;

	assign new_ent.cnt = req.tick_count;
	assign new_ent.id  = req.event_id;

	// list full when every cell is occupied
	assign full   = (count_q == COUNT_W'(DEPTH));
	// zero count and full list both reject the add
	assign add_ok = (op == OP_ADD) && (req.tick_count != '0) && !full;
	// head has expired: pop it
	assign pop_ok = (op == OP_CHECK) && (count_q != '0) && (cell_ent[0].cnt == '0);

	always_comb begin
		cmd     = CMD_HOLD;
		count_d = count_q;
		if (acc) begin
			case (op)
				OP_ADD: begin
					if (add_ok) begin
						cmd     = CMD_INSERT;
						count_d = count_q + COUNT_W'(1);
					end
				end
				OP_TICK: cmd = CMD_TICK;
				OP_CHECK: begin
					if (pop_ok) begin
						cmd     = CMD_SHIFT;
						count_d = count_q - COUNT_W'(1);
					end
				end
				OP_CLEAR: count_d = '0;
				default: cmd = CMD_HOLD;
			endcase
		end
	end

	// the chain: cell k takes from k-1 on insert, from k+1 on pop
	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		entry_t left_ent;
		logic   left_le;
		entry_t right_ent;

		assign cell_occ[k] = (COUNT_W'(k) < count_q);

		if (k == 0) begin : g_head
			// nothing to the left: the head takes the new event when it moves
			assign left_ent = new_ent;
			assign left_le  = 1'b1;
		end else begin : g_body
			assign left_ent = cell_ent[k-1];
			assign left_le  = cell_le[k-1];
		end

		if (k == DEPTH - 1) begin : g_tail
			// last cell becomes unoccupied on pop, its content is don't care
			assign right_ent = cell_ent[k];
		end else begin : g_mid
			assign right_ent = cell_ent[k+1];
		end

		stoq_cell u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.occ       (cell_occ[k]),
			.new_ent   (new_ent),
			.left_ent  (left_ent),
			.left_le   (left_le),
			.right_ent (right_ent),
			.ent       (cell_ent[k]),
			.le        (cell_le[k])
		);
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (acc) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload, loaded with each accepted transaction
	always_ff @(posedge clk) begin
		if (acc) begin
			fired_q    <= pop_ok;
			fired_id_q <= pop_ok ? cell_ent[0].id : '0;
			add_ok_q   <= add_ok;
			active_q   <= ACTIVE_W'(count_d);
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.fired        = fired_q;
	assign rsp.fired_id     = fired_id_q;
	assign rsp.add_accepted = add_ok_q;
	assign rsp.active_count = active_q;

	// occupancy never runs past the chain length
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(DEPTH))
		else $error("pending count exceeds depth");

	// a stored add grows the list by exactly one
	a_add_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && add_ok) |=> (count_q == $past(count_q) + COUNT_W'(1)))
		else $error("accepted add did not grow the list");

	// a pop reports the head id and shrinks the list by one
	a_pop_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && pop_ok) |=> (count_q == $past(count_q) - COUNT_W'(1)) && fired_q
			&& (fired_id_q == $past(cell_ent[0].id)))
		else $error("pop did not shrink the list or report the head");

	// clear empties the list
	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && (op == OP_CLEAR)) |=> (count_q == '0) && (active_q == '0))
		else $error("clear left events pending");

endmodule
